/* src/idqc_pkg.sv */
// ----------------------------------------------------------------------------
// idqc_pkg: shared definitions for the dotted-quad address checker
// Character codes, length limits, state widths and the octet rule check.
// ----------------------------------------------------------------------------
package idqc_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CCOUNT_W = 5;
    localparam int unsigned DCOUNT_W = 3;
    localparam int unsigned DIGITS_W = 3;
    localparam int unsigned VALUE_W  = 10;

    localparam logic [CHAR_W-1:0]   CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0]   CHAR_NINE = 8'd57;
    localparam logic [CHAR_W-1:0]   CHAR_DOT  = 8'd46;

    localparam logic [CCOUNT_W-1:0] MIN_LEN   = 5'd7;
    localparam logic [CCOUNT_W-1:0] MAX_LEN   = 5'd15;
    localparam logic [CCOUNT_W-1:0] CCOUNT_MAX = 5'd31;
    localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 3'd7;
    localparam logic [DCOUNT_W-1:0] DOTS_NEEDED = 3'd3;
    localparam logic [DIGITS_W-1:0] DIGITS_MAX = 3'd7;
    localparam logic [DIGITS_W-1:0] DIGITS_KEPT = 3'd3;
    localparam logic [VALUE_W-1:0]  OCTET_MAX = 10'd255;

    typedef logic [CCOUNT_W-1:0] t_ccount;
    typedef logic [DCOUNT_W-1:0] t_dcount;
    typedef logic [DIGITS_W-1:0] t_digits;
    typedef logic [VALUE_W-1:0]  t_value;

    // true if an octet breaks a rule; first marks the leading octet
    function automatic logic octet_bad(
        input t_digits digits,
        input t_value  value,
        input logic    lead_zero,
        input logic    first
    );
        logic bad;
        bad = 1'b0;
        if (digits == '0 || digits > DIGITS_KEPT) begin
            bad = 1'b1;
        end
        if (lead_zero && digits > t_digits'(1)) begin
            bad = 1'b1;
        end
        if (value > OCTET_MAX) begin
            bad = 1'b1;
        end
        if (first && value == '0) begin
            bad = 1'b1;
        end
        return bad;
    endfunction

endpackage

/* src/ipv4_dotted_quad_checker_core.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker_core
// Checks a character stream for a well-formed dotted-quad address and gives
// one verdict on each character marked as last.
// ----------------------------------------------------------------------------
// verdict is registered, valid the cycle after the final character is taken
// throughput: one character per cycle while o_in_ready is high, set by the
//   combinational update from the per-string counters to the verdict register
// a request is taken whenever the verdict register is empty or being drained
// reset: synchronous active low, clears all counters and the verdict valid
module ipv4_dotted_quad_checker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [idqc_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_last_char,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_address_valid
);
    import idqc_pkg::*;

    t_ccount r_char_count, n_char_count;
    t_dcount r_dot_count,  n_dot_count;
    t_digits r_digits,     n_digits;
    t_value  r_value,      n_value;
    logic    r_lead_zero,  n_lead_zero;
    logic    r_error,      n_error;
    logic    r_out_valid;
    logic    r_verdict,    n_verdict;

    logic       in_accept;
    logic       is_dot;
    logic       is_digit;
    logic [3:0] digit;

    assign o_in_ready      = !r_out_valid || i_out_ready;
    assign in_accept       = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_address_valid = r_verdict;

    // character classes
    assign is_dot   = (i_char_code == CHAR_DOT);
    assign is_digit = (i_char_code inside {[CHAR_ZERO:CHAR_NINE]});
    assign digit    = 4'(i_char_code - CHAR_ZERO);

    // next string state for the current character
    always_comb begin
        n_char_count = (r_char_count < CCOUNT_MAX) ? r_char_count + t_ccount'(1)
                                                   : r_char_count;
        n_dot_count  = r_dot_count;
        n_digits     = r_digits;
        n_value      = r_value;
        n_lead_zero  = r_lead_zero;
        n_error      = r_error;
        if (is_dot) begin
            if (n_char_count == t_ccount'(1)) begin
                n_error = 1'b1;
            end
            if (octet_bad(r_digits, r_value, r_lead_zero, r_dot_count == '0)) begin
                n_error = 1'b1;
            end
            if (r_dot_count < DCOUNT_MAX) begin
                n_dot_count = r_dot_count + t_dcount'(1);
            end
            n_digits    = '0;
            n_value     = '0;
            n_lead_zero = 1'b0;
        end else if (is_digit) begin
            if (r_digits == '0 && digit == 4'd0) begin
                n_lead_zero = 1'b1;
            end
            // times ten as two shifts, value stays below 1000
            if (r_digits < DIGITS_KEPT) begin
                n_value = (r_value << 3) + (r_value << 1) + t_value'(digit);
            end
            if (r_digits < DIGITS_MAX) begin
                n_digits = r_digits + t_digits'(1);
            end
        end else begin
            n_error = 1'b1;
        end
    end

    // verdict for a string ending on this character
    always_comb begin
        n_verdict = !n_error
                    && n_char_count >= MIN_LEN && n_char_count <= MAX_LEN
                    && n_dot_count == DOTS_NEEDED
                    && !octet_bad(n_digits, n_value, n_lead_zero, 1'b0);
    end

    // string state, cleared after each final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_dot_count  <= '0;
            r_digits     <= '0;
            r_value      <= '0;
            r_lead_zero  <= 1'b0;
            r_error      <= 1'b0;
        end else if (in_accept) begin
            if (i_last_char) begin
                r_char_count <= '0;
                r_dot_count  <= '0;
                r_digits     <= '0;
                r_value      <= '0;
                r_lead_zero  <= 1'b0;
                r_error      <= 1'b0;
            end else begin
                r_char_count <= n_char_count;
                r_dot_count  <= n_dot_count;
                r_digits     <= n_digits;
                r_value      <= n_value;
                r_lead_zero  <= n_lead_zero;
                r_error      <= n_error;
            end
        end
    end

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_char) begin
            r_verdict <= n_verdict;
        end
    end

endmodule
